FILE: design/mvba_pkg.sv
// Shared types, constants and helpers for the vector bitmap allocator.
// No dependencies; used by mvba_bitmap_mem and msi_vector_bitmap_allocator.
package mvba_pkg;

  localparam int SPI_W     = 10;
  localparam int MAX_SLOTS = 1024;
  localparam int WORD_W    = 32;
  localparam int BIT_W     = $clog2(WORD_W);
  localparam int NUM_ROWS  = MAX_SLOTS / WORD_W;
  localparam int ROW_W     = $clog2(NUM_ROWS);

  localparam logic [SPI_W-1:0] MIN_SPI = SPI_W'(32);
  localparam logic [SPI_W:0]   MAX_SPI = (SPI_W + 1)'(1019);

  typedef logic [SPI_W-1:0]  spi_t;
  typedef logic [WORD_W-1:0] word_t;
  typedef logic [ROW_W-1:0]  row_t;
  typedef logic [BIT_W-1:0]  bit_idx_t;

  // Request kinds
  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  // Result codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_OUTSIDE = 2'd2,
    ST_BADCFG  = 2'd3
  } status_t;

  // Register indexes on the configuration port
  typedef enum logic {
    REG_SPI_BASE  = 1'b0,
    REG_SPI_COUNT = 1'b1
  } reg_idx_t;

  // Bitmap memory access, one read and one write port
  typedef struct packed {
    logic  rd_en;
    row_t  rd_addr;
    logic  wr_en;
    row_t  wr_addr;
    word_t wr_data;
  } mem_req_t;

  typedef struct packed {
    logic     found;
    bit_idx_t idx;
  } zero_pos_t;

  // Lowest clear bit of a word
  function automatic zero_pos_t lowest_zero(input word_t w);
    zero_pos_t r;
    r.found = 1'b0;
    r.idx   = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!w[i]) begin
        r.found = 1'b1;
        r.idx   = BIT_W'(i);
      end
    end
    return r;
  endfunction

endpackage

FILE: design/mvba_bitmap_mem.sv
// Used-slot bitmap: 32-bit rows in a synchronous memory with a registered read.
// Per-row valid flags make unwritten rows read as all free after reset. Uses mvba_pkg.
module mvba_bitmap_mem
  import mvba_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  mem_req_t req,
  output word_t    rd_data
);

  word_t                mem [NUM_ROWS];
  logic  [NUM_ROWS-1:0] row_valid;
  word_t                rd_word;
  logic                 rd_valid;

  // Memory array: write and registered read
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_word <= mem[req.rd_addr];
    end
  end

  // Track which rows hold written data
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_valid  <= 1'b0;
    end else begin
      if (req.wr_en) begin
        row_valid[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_valid <= row_valid[req.rd_addr];
      end
    end
  end

  // Rows never written read as all free
  assign rd_data = rd_valid ? rd_word : '0;

endmodule

FILE: design/msi_vector_bitmap_allocator.sv
// Top level of the vector bitmap allocator: request sequencer, row summary
// and output register. Uses mvba_pkg and mvba_bitmap_mem.
//
// A request that is refused up front (bad window, free outside the window, or
// every row already full) goes from accept straight to the output register;
// one that touches the bitmap passes through accept, memory read,
// read-modify-write with priority encode, then load into the output register.
// The bitmap read-modify-write is serial; one request is in flight at a time.
// A register of row-full flags picks the row to read on allocate, so the
// search costs one memory read. The bitmap needs no clearing pass after reset.
module msi_vector_bitmap_allocator
  import mvba_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [9:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       op,
  input  logic [9:0] spi,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] status,
  output logic [9:0] granted_spi,
  output logic [9:0] parent_index
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_MODIFY,
    S_RESULT
  } state_t;

  state_t               state;
  spi_t                 spi_base;
  spi_t                 spi_count;
  logic [NUM_ROWS-1:0]  row_full;
  op_t                  cur_op;
  row_t                 cur_row;
  bit_idx_t             cur_bit;
  status_t              res_status;
  spi_t                 res_granted;
  mem_req_t             mem_req;
  word_t                rd_data;

  logic                 in_fire;
  logic                 out_free;
  logic                 cfg_ok;
  spi_t                 free_off;
  logic                 free_outside;
  zero_pos_t            row_pick;
  zero_pos_t            bit_pick;
  spi_t                 alloc_slot;
  logic                 alloc_ok;
  word_t                bit_mask;
  word_t                new_word;
  spi_t                 alloc_spi;

  mvba_bitmap_mem u_bitmap (
    .clk     (clk),
    .rst     (rst),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  // Window rules and request checks
  assign cfg_ok = (spi_base >= MIN_SPI) && (spi_count != '0) &&
                  (({1'b0, spi_base} + {1'b0, spi_count}) <= MAX_SPI);
  assign free_off     = spi - spi_base;
  assign free_outside = (spi < spi_base) || (free_off >= spi_count);
  assign row_pick     = lowest_zero(word_t'(row_full));

  // Slot search inside the row that was read
  assign bit_pick   = lowest_zero(rd_data);
  assign alloc_slot = {cur_row, bit_pick.idx};
  assign alloc_ok   = bit_pick.found && (alloc_slot < spi_count);
  assign bit_mask   = word_t'(1) << cur_bit;
  assign alloc_spi  = spi_base + alloc_slot;
  assign new_word   = (cur_op == OP_ALLOC) ? (rd_data | (word_t'(1) << bit_pick.idx))
                                           : (rd_data & ~bit_mask);

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Memory requests
  always_comb begin
    mem_req         = '0;
    mem_req.rd_en   = (state == S_READ);
    mem_req.rd_addr = cur_row;
    mem_req.wr_addr = cur_row;
    mem_req.wr_data = new_word;
    mem_req.wr_en   = (state == S_MODIFY) && ((cur_op == OP_FREE) || alloc_ok);
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      spi_base  <= SPI_W'(32);
      spi_count <= '0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_SPI_BASE:  spi_base  <= cfg_data;
        REG_SPI_COUNT: spi_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer, row summary and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      row_full  <= '0;
      out_valid <= 1'b0;
    end else begin
      // Drop the taken result unless a new one loads in this cycle
      if (out_valid && out_ready && (state != S_RESULT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            cur_op      <= op_t'(op);
            res_granted <= '0;
            if (!cfg_ok) begin
              res_status <= ST_BADCFG;
              state      <= S_RESULT;
            end else if (op_t'(op) == OP_ALLOC) begin
              cur_row <= row_pick.idx;
              if (!row_pick.found) begin
                res_status <= ST_FULL;
                state      <= S_RESULT;
              end else begin
                state <= S_READ;
              end
            end else begin
              cur_row <= free_off[SPI_W-1:BIT_W];
              cur_bit <= free_off[BIT_W-1:0];
              if (free_outside) begin
                res_status <= ST_OUTSIDE;
                state      <= S_RESULT;
              end else begin
                state <= S_READ;
              end
            end
          end
        end
        S_READ: begin
          state <= S_MODIFY;
        end
        S_MODIFY: begin
          if (mem_req.wr_en) begin
            row_full[cur_row] <= &new_word;
          end
          if (cur_op == OP_FREE) begin
            res_status <= ST_OK;
          end else if (alloc_ok) begin
            res_status  <= ST_OK;
            res_granted <= alloc_spi;
          end else begin
            res_status <= ST_FULL;
          end
          state <= S_RESULT;
        end
        S_RESULT: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            status       <= res_status;
            granted_spi  <= res_granted;
            parent_index <= (res_granted != '0) ? (res_granted - MIN_SPI) : '0;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A taken transaction closes the input until its result is loaded
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !in_ready)
    else $error("input accepted while a transaction is in flight");

  // Bitmap writes come only from the modify step
  a_write_in_modify: assert property (@(posedge clk) disable iff (rst)
    mem_req.wr_en |-> (state == S_MODIFY))
    else $error("bitmap written outside the modify step");

  // A grant always carries its parent index
  a_parent_index: assert property (@(posedge clk) disable iff (rst)
    (out_valid && granted_spi != '0) |->
      (parent_index == granted_spi - MIN_SPI) && (status == ST_OK))
    else $error("parent index does not match granted number");

  // Failed results carry no number
  a_no_grant_on_fail: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> (granted_spi == '0) && (parent_index == '0))
    else $error("number reported on a failed transaction");

endmodule
